// ===== design/qsg_pkg.sv =====
// shared types, widths and codes for the quadrature step generator
// used by qsg_incr, qsg_track and quadrature_step_generator
`default_nettype none

package qsg_pkg;

	// position wrap width
	localparam int POS_BITS = 48;

	// field widths
	localparam int ACTION_W   = 2;
	localparam int AMOUNT_W   = 48;
	localparam int SPEED_W    = 32;
	localparam int INTERVAL_W = 32;
	localparam int POSVAL_W   = 48;
	localparam int UNITS_W    = 47;
	localparam int PHASE_W    = 2;
	localparam int STEP_W     = 2;

	// Q16.16 time scaling and increment magnitude width
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = SPEED_W + INTERVAL_W;
	localparam int MAG_W     = (AMOUNT_W > PROD_W - FRAC_BITS) ? AMOUNT_W : PROD_W - FRAC_BITS;
	localparam int CMP_W     = ((POS_BITS > UNITS_W) ? POS_BITS : UNITS_W) + 1;

	// stream packing
	localparam int S_TDATA_W = AMOUNT_W + SPEED_W + INTERVAL_W + POSVAL_W;
	localparam int S_TUSER_W = ACTION_W;
	localparam int RES_W     = 1 + PHASE_W + STEP_W;
	localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

	// configuration port
	localparam int CFG_NUM   = 2;
	localparam int CFG_IDX_W = $clog2(CFG_NUM);
	localparam logic [CFG_IDX_W-1:0] REG_STEP_UNITS    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_UNITS = CFG_IDX_W'(1);
	localparam logic [UNITS_W-1:0]   STEP_UNITS_RST    = UNITS_W'(256);
	localparam logic [UNITS_W-1:0]   TRIGGER_UNITS_RST = UNITS_W'(128);

	// action codes
	localparam logic [ACTION_W-1:0] ACT_SHIFT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SPEED   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_PRELOAD = 2'd2;

	// step codes
	localparam logic [STEP_W-1:0] STEP_NONE = 2'd0;
	localparam logic [STEP_W-1:0] STEP_FWD  = 2'd1;
	localparam logic [STEP_W-1:0] STEP_BWD  = 2'd2;

	// status codes
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_OVERRUN = 1'b1;

	// increment handed from the front stage to the tracker
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                neg;
		logic [MAG_W-1:0]    mag;
		logic [POS_BITS-1:0] preload;
	} qsg_incr_t;

	// one result beat
	typedef struct packed {
		logic [STEP_W-1:0]  step_taken;
		logic [PHASE_W-1:0] phase;
		logic               status;
	} qsg_result_t;

endpackage

`default_nettype wire

// ===== design/qsg_incr.sv =====
// front stages: input register, then sign/magnitude of the increment
// (direct amount or speed times Q16.16 interval); depends on qsg_pkg
`default_nettype none

module qsg_incr (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [qsg_pkg::ACTION_W-1:0]   in_action,
	input  wire logic [qsg_pkg::AMOUNT_W-1:0]   in_amount,
	input  wire logic [qsg_pkg::SPEED_W-1:0]    in_speed,
	input  wire logic [qsg_pkg::INTERVAL_W-1:0] in_interval,
	input  wire logic [qsg_pkg::POSVAL_W-1:0]   in_position,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output qsg_pkg::qsg_incr_t                out_beat
);
	import qsg_pkg::*;

	logic                  valid_s1;
	logic [ACTION_W-1:0]   action_s1;
	logic [AMOUNT_W-1:0]   amount_s1;
	logic [SPEED_W-1:0]    speed_s1;
	logic [INTERVAL_W-1:0] interval_s1;
	logic [POSVAL_W-1:0]   position_s1;

	logic                  valid_s2;
	qsg_incr_t             beat_s2;

	logic                  ready_s1;
	logic                  ready_s2;
	logic                  amount_neg;
	logic [AMOUNT_W-1:0]   amount_mag;
	logic                  speed_neg;
	logic [SPEED_W-1:0]    speed_mag;
	logic [PROD_W-1:0]     product;
	qsg_incr_t             beat_d;

	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			action_s1   <= in_action;
			amount_s1   <= in_amount;
			speed_s1    <= in_speed;
			interval_s1 <= in_interval;
			position_s1 <= in_position;
		end
	end

	// magnitudes; the most negative value maps to its unsigned magnitude
	assign amount_neg = amount_s1[AMOUNT_W-1];
	assign amount_mag = amount_neg ? (AMOUNT_W'(0) - amount_s1) : amount_s1;
	assign speed_neg  = speed_s1[SPEED_W-1];
	assign speed_mag  = speed_neg ? (SPEED_W'(0) - speed_s1) : speed_s1;
	assign product    = PROD_W'(speed_mag) * PROD_W'(interval_s1);

	always_comb begin
		beat_d         = '0;
		beat_d.action  = action_s1;
		beat_d.preload = POS_BITS'($signed(position_s1));
		unique case (action_s1)
			ACT_SHIFT: begin
				beat_d.neg = amount_neg;
				beat_d.mag = MAG_W'(amount_mag);
			end
			ACT_SPEED: begin
				beat_d.neg = speed_neg;
				beat_d.mag = MAG_W'(product >> FRAC_BITS);
			end
			default: begin
				beat_d.neg = 1'b0;
				beat_d.mag = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			beat_s2 <= beat_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_beat  = beat_s2;

endmodule

`default_nettype wire

// ===== design/qsg_track.sv =====
// position tracker: lead of commanded over stepped position, phase,
// step decision and the result register; depends on qsg_pkg
`default_nettype none

module qsg_track (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [qsg_pkg::UNITS_W-1:0] step_units,
	input  wire logic [qsg_pkg::UNITS_W-1:0] trigger_units,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire qsg_pkg::qsg_incr_t        in_beat,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output qsg_pkg::qsg_result_t           out_result
);
	import qsg_pkg::*;

	// only the difference of the two positions matters for stepping
	logic [POS_BITS-1:0] lead_q;
	logic [PHASE_W-1:0]  phase_q;
	logic                valid_q;
	qsg_result_t         result_q;

	logic                take;
	logic [POS_BITS-1:0] mag_p;
	logic [POS_BITS-1:0] step_p;
	logic [POS_BITS-1:0] diff;
	logic [POS_BITS-1:0] lag;
	logic                overrun;
	logic                go_fwd;
	logic                go_bwd;
	logic [POS_BITS-1:0] lead_d;
	logic [PHASE_W-1:0]  phase_d;
	qsg_result_t         result_d;

	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	assign mag_p  = POS_BITS'(in_beat.mag);
	assign step_p = POS_BITS'(step_units);

	// new lead and its negation side by side
	assign diff = in_beat.neg ? (lead_q - mag_p) : (lead_q + mag_p);
	assign lag  = in_beat.neg ? (mag_p - lead_q) : (POS_BITS'(0) - lead_q - mag_p);

	assign overrun = in_beat.mag >= MAG_W'(step_units);
	assign go_fwd  = !diff[POS_BITS-1] && (CMP_W'(diff) > CMP_W'(trigger_units));
	assign go_bwd  = diff[POS_BITS-1] && (CMP_W'(lag) > CMP_W'(trigger_units));

	always_comb begin
		lead_d              = lead_q;
		phase_d             = phase_q;
		result_d.status     = ST_OK;
		result_d.step_taken = STEP_NONE;
		unique case (in_beat.action)
			ACT_SHIFT, ACT_SPEED: begin
				priority if (overrun) begin
					result_d.status = ST_OVERRUN;
				end else if (go_fwd) begin
					lead_d              = diff - step_p;
					phase_d             = phase_q + PHASE_W'(1);
					result_d.step_taken = STEP_FWD;
				end else if (go_bwd) begin
					lead_d              = diff + step_p;
					phase_d             = phase_q - PHASE_W'(1);
					result_d.step_taken = STEP_BWD;
				end else begin
					lead_d = diff;
				end
			end
			ACT_PRELOAD: begin
				lead_d = '0;
			end
			default: begin
				lead_d = lead_q;
			end
		endcase
		result_d.phase = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q  <= '0;
			phase_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (take) begin
				lead_q  <= lead_d;
				phase_q <= phase_d;
			end
			if (in_ready) begin
				valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= result_d;
		end
	end

	assign out_valid  = valid_q;
	assign out_result = result_q;

endmodule

`default_nettype wire

// ===== design/quadrature_step_generator.sv =====
// quadrature step generator top: config registers, front stages, tracker
// a taken input beat passes the input register, then the increment register, then the result register
// throughput: one beat per cycle while the result stream is not stalled; the lead/phase loop is combinational
// input ready falls only when all three stage registers hold beats
// async reset: step_units 256, trigger_units 128, positions and phase zero
`default_nettype none

module quadrature_step_generator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input stream
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// amount [47:0], speed [79:48], interval [111:80], position_value [159:112]
	input  wire logic [qsg_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// action [1:0]
	input  wire logic [qsg_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	// result stream
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// status [0], phase [2:1], step_taken [4:3], zero fill above
	output logic [qsg_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	// register writes
	input  wire logic                           cfg_we,
	input  wire logic [qsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [qsg_pkg::UNITS_W-1:0]    cfg_wdata
);
	import qsg_pkg::*;

	// configuration; the user writes it only while the block is idle, not enforced
	logic [UNITS_W-1:0] step_units_q;
	logic [UNITS_W-1:0] trigger_units_q;

	// beat between front stages and tracker
	logic        incr_valid;
	logic        incr_ready;
	qsg_incr_t   incr_beat;
	qsg_result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_units_q    <= STEP_UNITS_RST;
			trigger_units_q <= TRIGGER_UNITS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_UNITS:    step_units_q    <= cfg_wdata;
				REG_TRIGGER_UNITS: trigger_units_q <= cfg_wdata;
				default: begin
					step_units_q <= step_units_q;
				end
			endcase
		end
	end

	// input register and increment magnitude (two stages)
	qsg_incr u_incr (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_action   (s_axis_tuser[ACTION_W-1:0]),
		.in_amount   (s_axis_tdata[AMOUNT_W-1:0]),
		.in_speed    (s_axis_tdata[AMOUNT_W +: SPEED_W]),
		.in_interval (s_axis_tdata[AMOUNT_W+SPEED_W +: INTERVAL_W]),
		.in_position (s_axis_tdata[AMOUNT_W+SPEED_W+INTERVAL_W +: POSVAL_W]),
		.out_valid   (incr_valid),
		.out_ready   (incr_ready),
		.out_beat    (incr_beat)
	);

	// lead/phase state update and result register
	qsg_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_units    (step_units_q),
		.trigger_units (trigger_units_q),
		.in_valid      (incr_valid),
		.in_ready      (incr_ready),
		.in_beat       (incr_beat),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_result    (result)
	);

	assign m_axis_tdata = M_TDATA_W'(result);

	// an overrun never moves the motor
	a_overrun_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (result.status == ST_OVERRUN) |-> result.step_taken == STEP_NONE)
		else $error("overrun beat reports a step");

	// step code is one of the three defined codes
	a_step_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (result.step_taken == STEP_NONE) ||
			(result.step_taken == STEP_FWD) || (result.step_taken == STEP_BWD))
		else $error("undefined step code on result");

	// with the result register empty the pipeline must take input
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

	// a beat held between stages is not dropped
	a_inner_hold: assert property (@(posedge clk) disable iff (!arst_n)
		incr_valid && !incr_ready |=> incr_valid)
		else $error("inner beat lost while stalled");

endmodule

`default_nettype wire

// ===== test/quadrature_step_generator_test.sv =====
// self-checking testbench for quadrature_step_generator: random and directed beats
// against an in-bench position/phase tracker; needs qsg_pkg and the block's rtl only

module quadrature_step_generator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import qsg_pkg::*;

	// the fourth action code has no name in the package; the block ignores it
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	// longest run before the watchdog gives up, in ns
	localparam int RUN_LIMIT_NS = 400_000;
	// mismatch lines printed before going quiet
	localparam int MAX_REPORTS = 40;

	// one input beat, field by field
	typedef struct {
		logic [ACTION_W-1:0]          action;
		logic signed [AMOUNT_W-1:0]   amount;
		logic signed [SPEED_W-1:0]    speed;
		logic [INTERVAL_W-1:0]        interval;
		logic signed [POSVAL_W-1:0]   position_value;
	} motion_cmd_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// amount [47:0], speed [79:48], interval [111:80], position_value [159:112]
	logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
	// action [1:0]
	logic [S_TUSER_W-1:0]   s_axis_tuser  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// status [0], phase [2:1], step_taken [4:3], zero fill above
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic                   cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index     = '0;
	logic [UNITS_W-1:0]     cfg_wdata     = '0;

	// tracker state mirrored from the block, reset values from the package
	logic [POS_BITS-1:0]    cmd_pos      = '0;
	logic [POS_BITS-1:0]    stp_pos      = '0;
	logic [PHASE_W-1:0]     cur_phase    = '0;
	logic [UNITS_W-1:0]     step_size    = STEP_UNITS_RST;
	logic [UNITS_W-1:0]     trigger_dist = TRIGGER_UNITS_RST;

	// results still owed by the block, oldest first
	qsg_result_t            expected_results[$];
	int                     fail_count    = 0;
	// idle odds in percent for each side, and a forced receiver hold-off
	int                     send_idle_pct = 0;
	int                     recv_idle_pct = 0;
	int                     hold_cycles   = 0;

	quadrature_step_generator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		#RUN_LIMIT_NS;
		$display("simulation failed");
		$finish;
	end

	// advance the tracker by one accepted beat and return the result it owes
	function automatic qsg_result_t predict_result(motion_cmd_t c);
		qsg_result_t          r;
		logic                 neg;
		logic                 shifting;
		logic [63:0]          wide;
		logic [63:0]          mag;
		logic [POS_BITS-1:0]  lead;
		logic [POS_BITS-1:0]  lag;
		r.status     = ST_OK;
		r.step_taken = STEP_NONE;
		shifting     = 1'b0;
		neg          = 1'b0;
		mag          = '0;
		case (c.action)
			ACT_SHIFT: begin
				wide     = {{(64-AMOUNT_W){c.amount[AMOUNT_W-1]}}, c.amount};
				neg      = c.amount[AMOUNT_W-1];
				mag      = neg ? 64'd0 - wide : wide;
				shifting = 1'b1;
			end
			ACT_SPEED: begin
				// sign and magnitude; the most negative speed keeps magnitude 2^31
				wide     = {{(64-SPEED_W){c.speed[SPEED_W-1]}}, c.speed};
				neg      = c.speed[SPEED_W-1];
				mag      = ((neg ? 64'd0 - wide : wide) * 64'(c.interval)) >> FRAC_BITS;
				shifting = 1'b1;
			end
			ACT_PRELOAD: begin
				cmd_pos = POS_BITS'(c.position_value);
				stp_pos = POS_BITS'(c.position_value);
			end
			default: begin
				// unused action: nothing moves
			end
		endcase
		if (shifting) begin
			// a zero step size turns every increment into an overrun
			if (mag >= 64'(step_size)) begin
				r.status = ST_OVERRUN;
			end else begin
				cmd_pos = neg ? cmd_pos - POS_BITS'(mag) : cmd_pos + POS_BITS'(mag);
				lead    = cmd_pos - stp_pos;
				lag     = POS_BITS'(0) - lead;
				// lead read as signed; zero lead never steps
				if (lead != 0 && !lead[POS_BITS-1]) begin
					if (64'(lead) > 64'(trigger_dist)) begin
						cur_phase    = cur_phase + 2'd1;
						stp_pos      = stp_pos + POS_BITS'(step_size);
						r.step_taken = STEP_FWD;
					end
				end else if (lead != 0 && 64'(lag) > 64'(trigger_dist)) begin
					cur_phase    = cur_phase - 2'd1;
					stp_pos      = stp_pos - POS_BITS'(step_size);
					r.step_taken = STEP_BWD;
				end
			end
		end
		r.phase = cur_phase;
		return r;
	endfunction

	// every field random, any action
	function automatic motion_cmd_t noise_cmd();
		motion_cmd_t c;
		c.action         = ACTION_W'($urandom);
		c.amount         = AMOUNT_W'({$urandom, $urandom});
		c.speed          = $urandom;
		c.interval       = $urandom;
		c.position_value = POSVAL_W'({$urandom, $urandom});
		return c;
	endfunction

	// mostly increments that fit under the current step size, so the tracker
	// actually moves; the rest is noise, boundary overruns, preloads, unused codes
	function automatic motion_cmd_t random_cmd();
		motion_cmd_t  c;
		logic [63:0]  m;
		logic [63:0]  lim;
		logic         neg;
		int unsigned  sel;
		c   = noise_cmd();
		sel = $urandom_range(99);
		neg = 1'($urandom_range(1));
		if (sel < 6)
			return c;
		if (sel < 50) begin
			c.action = ACT_SHIFT;
			if (step_size == 0)
				m = 64'($urandom_range(3));
			else if ($urandom_range(9) == 0)
				m = 64'(step_size) - 64'($urandom_range(1));
			else
				m = {$urandom, $urandom} % 64'(step_size);
			c.amount = AMOUNT_W'(neg ? 64'd0 - m : m);
		end else if (sel < 86) begin
			c.action = ACT_SPEED;
			// short intervals mostly, full-range ones now and then
			if ($urandom_range(3) != 0)
				c.interval = $urandom_range(1 << 18);
			if (c.interval != 0) begin
				lim = (64'(step_size) << FRAC_BITS) / 64'(c.interval);
				if (lim > 64'h7FFF_FFFF)
					lim = 64'h7FFF_FFFF;
				m       = {$urandom, $urandom} % (lim + 64'd1);
				c.speed = SPEED_W'(neg ? 64'd0 - m : m);
			end
		end else if (sel < 94) begin
			c.action = ACT_PRELOAD;
			// half the preloads sit just below the signed top of the position range
			if ($urandom_range(1))
				c.position_value = POSVAL_W'(64'h7FFF_FFFF_FFFF - 64'($urandom_range(4095)));
		end else begin
			c.action = ACT_UNUSED;
		end
		return c;
	endfunction

	function automatic void check_field(string field, int want, int got);
		if (want != got) begin
			if (fail_count < MAX_REPORTS)
				$display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
			fail_count++;
		end
	endfunction

	// offer one beat after a random gap, hold it until taken, then predict
	task automatic send_beat(input motion_cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {c.position_value, c.interval, c.speed, c.amount};
		s_axis_tuser  <= c.action;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_results.push_back(predict_result(c));
	endtask

	task automatic send_many(input int n);
		repeat (n) send_beat(random_cmd());
	endtask

	task automatic send_shift(input logic [AMOUNT_W-1:0] amt);
		motion_cmd_t c;
		c        = noise_cmd();
		c.action = ACT_SHIFT;
		c.amount = amt;
		send_beat(c);
	endtask

	task automatic send_speed(input logic [SPEED_W-1:0] spd, input logic [INTERVAL_W-1:0] itv);
		motion_cmd_t c;
		c          = noise_cmd();
		c.action   = ACT_SPEED;
		c.speed    = spd;
		c.interval = itv;
		send_beat(c);
	endtask

	task automatic send_preload(input logic [POSVAL_W-1:0] pos);
		motion_cmd_t c;
		c                = noise_cmd();
		c.action         = ACT_PRELOAD;
		c.position_value = pos;
		send_beat(c);
	endtask

	task automatic send_unused(input bit all_ones);
		motion_cmd_t c;
		c        = noise_cmd();
		c.action = ACT_UNUSED;
		if (all_ones) begin
			c.amount         = '1;
			c.speed          = '1;
			c.interval       = '1;
			c.position_value = '1;
		end
		send_beat(c);
	endtask

	// stop offering, wait out every owed result, then the pipeline depth
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// one register write; the spare edge keeps back-to-back writes apart
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [UNITS_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == REG_STEP_UNITS)
			step_size = value;
		else if (idx == REG_TRIGGER_UNITS)
			trigger_dist = value;
	endtask

	// registers change only with the block empty
	task automatic set_registers(input logic [UNITS_W-1:0] step, input logic [UNITS_W-1:0] trig);
		drain_results();
		write_reg(REG_STEP_UNITS, step);
		write_reg(REG_TRIGGER_UNITS, trig);
	endtask

	// hand-picked beats at reset settings: step 256, trigger 128
	task automatic test_directed();
		send_shift(48'sd255);                 // largest legal increment, steps forward
		send_shift(48'sd256);                 // exactly one step: overrun
		send_shift(-48'sd256);                // overrun backward
		send_shift(-48'sd255);                // steps back
		send_shift(-48'sd128);                // lag equal to trigger: no step
		send_shift(-48'sd1);                  // lag past trigger, phase wraps 0 to 3
		send_shift(48'h7FFF_FFFF_FFFF);       // most positive amount
		send_shift(48'h8000_0000_0000);       // most negative amount
		send_shift(48'sd0);
		send_speed(32'sd255, 32'h0001_0000);  // 255 units over one time unit
		send_speed(-32'sd1, 32'h0000_FFFF);   // below one unit, truncates to zero
		send_speed(-32'sd3, 32'h0001_8000);   // -4.5 truncates toward zero
		send_speed(32'h8000_0000, 32'h0000_0000);
		send_speed(32'h8000_0000, 32'hFFFF_FFFF);
		send_speed(32'h7FFF_FFFF, 32'h0000_0001);
		send_speed(32'sd0, 32'hFFFF_FFFF);
		send_preload(48'h7FFF_FFFF_FFFF);     // phase kept, positions jump
		send_shift(48'sd200);                 // forward across the signed top
		send_preload(48'h8000_0000_0000);
		send_shift(-48'sd200);                // backward across the signed bottom
		send_preload(48'sd0);
		send_shift(48'sd0);                   // zero lead never steps
		send_unused(1'b1);
		send_unused(1'b0);
	endtask

	// largest and smallest register values, including a zero step size
	task automatic test_register_extremes();
		set_registers('1, '0);
		send_many(40);
		set_registers(UNITS_W'(1), '0);
		send_many(30);
		set_registers('0, UNITS_W'(5));
		send_many(25);
		set_registers('1, '1);
		send_many(30);
		set_registers(STEP_UNITS_RST, TRIGGER_UNITS_RST);
	endtask

	// receiver stalls long while the sender keeps offering, so input ready
	// must drop; then the sender waits for every result before moving on
	task automatic test_backpressure();
		send_idle_pct = 0;
		hold_cycles   = 120;
		send_many(40);
		drain_results();
	endtask

	// fresh random register pair, then a long run at the given idle odds
	task automatic test_random_traffic(input int s_pct, input int r_pct, input int n);
		logic [UNITS_W-1:0] step;
		step = UNITS_W'({$urandom, $urandom}) >> $urandom_range(UNITS_W - 2, 2);
		if (step == 0)
			step = UNITS_W'(1);
		set_registers(step, step >> $urandom_range(3, 1));
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		send_many(n);
	endtask

	// receiver: forced hold-off first, otherwise random ready
	initial begin : drive_ready
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// every result beat is matched against the oldest owed result
	always @(posedge clk) begin : check_results
		qsg_result_t got;
		qsg_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = qsg_result_t'(m_axis_tdata[RES_W-1:0]);
			if (expected_results.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("%0t result beat with none owed: expected none actual %0h",
						$time, m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("status", want.status, got.status);
				check_field("phase", want.phase, got.phase);
				check_field("step_taken", want.step_taken, got.step_taken);
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		send_idle_pct = 30;
		recv_idle_pct = 56;
		test_directed();
		test_register_extremes();
		test_backpressure();
		test_random_traffic(30, 56, 500);
		test_random_traffic(56, 30, 500);
		test_random_traffic(0, 0, 500);
		drain_results();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
